>>> sv/assert_macros.svh
// Assertion macros for the heap allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset
`define FFH_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the default clock and reset names
`define FFH_ASSERT(label, prop, msg) `FFH_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> sv/ffh_pkg.sv
// Shared types and constants for the first-fit heap allocator
`timescale 1ns / 1ps
package ffh_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int ADDR_BITS_DEF    = 32;

  localparam int FIELD_W = 32;
  localparam int PADDR_W = 3;
  localparam logic [31:0] HEAP_LIMIT_RST = 32'd65536;
  localparam logic CFG_HEAP_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_CALLOC = 2'd1,
    REQ_RESIZE = 2'd2,
    REQ_FREE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADREQ  = 2'd2,
    ST_BADADDR = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DECODE,
    CS_MUL,
    CS_CHECK,
    CS_FIND,
    CS_FIT,
    CS_APPEND,
    CS_RELEASE,
    CS_RESPOND
  } ctrl_state_e;

  typedef struct packed {
    logic    latch_in;
    logic    mul;
    logic    want_prod;
    logic    scan_start;
    logic    scan_addr;
    logic    scan_run;
    logic    res_addr;
    logic    append;
    logic    release_old;
    logic    out_load;
    status_e out_status;
    logic    out_res;
    logic    out_zf;
    logic    out_move;
  } cmd_t;

  typedef struct packed {
    req_e req_type;
    logic bytes_zero;
    logic count_zero;
    logic addr_zero;
    logic prod_ovf;
    logic scan_hit;
    logic scan_done;
    logic size_ok;
    logic table_full;
    logic heap_over;
    logic out_free;
  } sts_t;

endpackage

>>> sv/ffh_req_if.sv
// Request channel interface
`timescale 1ns / 1ps
interface ffh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] request_bytes;
  logic [31:0] element_count;
  logic [31:0] address;

  modport source (output valid, req_type, request_bytes, element_count, address,
                  input ready);
  modport sink (input valid, req_type, request_bytes, element_count, address,
                output ready);
endinterface

>>> sv/ffh_rsp_if.sv
// Result channel interface
`timescale 1ns / 1ps
interface ffh_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_address;
  logic        zero_fill;
  logic [31:0] copy_source;
  logic [31:0] copy_bytes;

  modport source (output valid, status, result_address, zero_fill, copy_source,
                  copy_bytes, input ready);
  modport sink (input valid, status, result_address, zero_fill, copy_source,
                copy_bytes, output ready);
endinterface

>>> sv/ffh_ctrl.sv
// Request sequencer for the heap allocator
`timescale 1ns / 1ps
module ffh_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ffh_pkg::sts_t sts_i,
  output ffh_pkg::cmd_t cmd_o
);

  ffh_pkg::ctrl_state_e st_q, st_d;
  ffh_pkg::status_e     status_q, status_d;
  logic zf_q, zf_d, move_q, move_d, res_ok_q, res_ok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ffh_pkg::CS_IDLE;
      status_q <= ffh_pkg::ST_OK;
      zf_q     <= 1'b0;
      move_q   <= 1'b0;
      res_ok_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      status_q <= status_d;
      zf_q     <= zf_d;
      move_q   <= move_d;
      res_ok_q <= res_ok_d;
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ffh_pkg::CS_IDLE: begin
        if (in_valid_i) st_d = ffh_pkg::CS_DECODE;
      end
      ffh_pkg::CS_DECODE: begin
        case (sts_i.req_type)
          ffh_pkg::REQ_ALLOC:
            st_d = sts_i.bytes_zero ? ffh_pkg::CS_RESPOND : ffh_pkg::CS_FIT;
          ffh_pkg::REQ_CALLOC:
            st_d = (sts_i.bytes_zero || sts_i.count_zero) ? ffh_pkg::CS_RESPOND
                                                           : ffh_pkg::CS_MUL;
          ffh_pkg::REQ_RESIZE: begin
            if (sts_i.bytes_zero)     st_d = ffh_pkg::CS_RESPOND;
            else if (sts_i.addr_zero) st_d = ffh_pkg::CS_FIT;
            else                      st_d = ffh_pkg::CS_FIND;
          end
          default:
            st_d = sts_i.addr_zero ? ffh_pkg::CS_RESPOND : ffh_pkg::CS_FIND;
        endcase
      end
      ffh_pkg::CS_MUL: st_d = ffh_pkg::CS_CHECK;
      ffh_pkg::CS_CHECK: begin
        st_d = sts_i.prod_ovf ? ffh_pkg::CS_RESPOND : ffh_pkg::CS_FIT;
      end
      ffh_pkg::CS_FIND: begin
        if (sts_i.scan_hit) begin
          if (sts_i.req_type == ffh_pkg::REQ_FREE) st_d = ffh_pkg::CS_RELEASE;
          else if (sts_i.size_ok)                  st_d = ffh_pkg::CS_RESPOND;
          else                                     st_d = ffh_pkg::CS_FIT;
        end else if (sts_i.scan_done) begin
          st_d = ffh_pkg::CS_RESPOND;
        end
      end
      ffh_pkg::CS_FIT: begin
        if (sts_i.scan_hit)
          st_d = move_q ? ffh_pkg::CS_RELEASE : ffh_pkg::CS_RESPOND;
        else if (sts_i.scan_done)
          st_d = ffh_pkg::CS_APPEND;
      end
      ffh_pkg::CS_APPEND: begin
        if (sts_i.table_full || sts_i.heap_over) st_d = ffh_pkg::CS_RESPOND;
        else st_d = move_q ? ffh_pkg::CS_RELEASE : ffh_pkg::CS_RESPOND;
      end
      ffh_pkg::CS_RELEASE: st_d = ffh_pkg::CS_RESPOND;
      ffh_pkg::CS_RESPOND: begin
        if (sts_i.out_free) st_d = ffh_pkg::CS_IDLE;
      end
      default: st_d = ffh_pkg::CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.out_status = ffh_pkg::ST_OK;
    in_ready_o = 1'b0;
    status_d   = status_q;
    zf_d       = zf_q;
    move_d     = move_q;
    res_ok_d   = res_ok_q;
    case (st_q)
      ffh_pkg::CS_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      ffh_pkg::CS_DECODE: begin
        status_d = ffh_pkg::ST_OK;
        zf_d     = 1'b0;
        move_d   = 1'b0;
        res_ok_d = 1'b0;
        case (sts_i.req_type)
          ffh_pkg::REQ_ALLOC: begin
            if (sts_i.bytes_zero) status_d = ffh_pkg::ST_BADREQ;
            else cmd_o.scan_start = 1'b1;
          end
          ffh_pkg::REQ_CALLOC: begin
            if (sts_i.bytes_zero || sts_i.count_zero) status_d = ffh_pkg::ST_BADREQ;
          end
          ffh_pkg::REQ_RESIZE: begin
            if (sts_i.bytes_zero) begin
              status_d = ffh_pkg::ST_BADREQ;
            end else begin
              cmd_o.scan_start = 1'b1;
              cmd_o.scan_addr  = !sts_i.addr_zero;
            end
          end
          default: begin
            if (!sts_i.addr_zero) begin
              cmd_o.scan_start = 1'b1;
              cmd_o.scan_addr  = 1'b1;
            end
          end
        endcase
      end
      ffh_pkg::CS_MUL: cmd_o.mul = 1'b1;
      ffh_pkg::CS_CHECK: begin
        if (sts_i.prod_ovf) begin
          status_d = ffh_pkg::ST_BADREQ;
        end else begin
          cmd_o.want_prod  = 1'b1;
          cmd_o.scan_start = 1'b1;
          zf_d             = 1'b1;
        end
      end
      ffh_pkg::CS_FIND: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_hit) begin
          if (sts_i.req_type != ffh_pkg::REQ_FREE) begin
            if (sts_i.size_ok) begin
              cmd_o.res_addr = 1'b1;
              res_ok_d       = 1'b1;
            end else begin
              move_d           = 1'b1;
              cmd_o.scan_start = 1'b1;
            end
          end
        end else if (sts_i.scan_done) begin
          status_d = ffh_pkg::ST_BADADDR;
        end
      end
      ffh_pkg::CS_FIT: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_hit) res_ok_d = 1'b1;
      end
      ffh_pkg::CS_APPEND: begin
        if (sts_i.table_full || sts_i.heap_over) begin
          status_d = ffh_pkg::ST_NOMEM;
        end else begin
          cmd_o.append = 1'b1;
          res_ok_d     = 1'b1;
        end
      end
      ffh_pkg::CS_RELEASE: cmd_o.release_old = 1'b1;
      ffh_pkg::CS_RESPOND: begin
        cmd_o.out_load   = sts_i.out_free;
        cmd_o.out_status = status_q;
        cmd_o.out_res    = res_ok_q && (status_q == ffh_pkg::ST_OK);
        cmd_o.out_zf     = zf_q && (status_q == ffh_pkg::ST_OK);
        cmd_o.out_move   = move_q && (status_q == ffh_pkg::ST_OK);
      end
      default: ;
    endcase
  end

endmodule

>>> sv/ffh_datapath.sv
// Block table memory, break pointer, multiplier and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffh_datapath #(
  parameter int MAX_BLOCKS   = ffh_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffh_pkg::HEADER_BYTES_DEF,
  parameter int ADDR_BITS    = ffh_pkg::ADDR_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ffh_pkg::cmd_t cmd_i,
  output ffh_pkg::sts_t sts_o,
  input  logic [31:0]   limit_i,
  input  logic [1:0]    req_type_i,
  input  logic [31:0]   request_bytes_i,
  input  logic [31:0]   element_count_i,
  input  logic [31:0]   address_i,
  input  logic          rsp_ready_i,
  output logic          rsp_valid_o,
  output logic [1:0]    status_o,
  output logic [31:0]   result_address_o,
  output logic          zero_fill_o,
  output logic [31:0]   copy_source_o,
  output logic [31:0]   copy_bytes_o
);

  localparam int VW = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam int SW = VW + 2;
  localparam int EW = 2 * VW + 1;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [SW-1:0] HDR     = SW'(HEADER_BYTES);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

  logic [EW-1:0] mem [MAX_BLOCKS];

  logic [1:0]    type_q;
  logic [31:0]   bytes_q, elem_q, addr_q;
  logic [63:0]   prod_q;
  logic [VW-1:0] want_q;
  logic [CW-1:0] idx_q, ecount_q;
  logic          pend_q, mode_q;
  logic [IW-1:0] pidx_q, old_idx_q;
  logic [EW-1:0] rdata_q;
  logic [VW-1:0] old_start_q, old_size_q, brk_q;
  logic [31:0]   res_q;
  logic          out_valid_q;

  logic [VW-1:0] r_start, r_size;
  logic          r_free, match, hit, old_last;
  logic [VW:0]   r_pay;
  logic [SW-1:0] nb, brk_pay;
  logic [IW-1:0] rd_idx, mem_wa;
  logic [EW-1:0] mem_wd;
  logic          mem_we;

  assign r_start  = rdata_q[EW-1 -: VW];
  assign r_size   = rdata_q[VW:1];
  assign r_free   = rdata_q[0];
  assign r_pay    = {1'b0, r_start} + HDR[VW:0];
  assign match    = mode_q ? (r_pay == (VW+1)'(addr_q))
                           : (r_free && (r_size >= want_q));
  assign hit      = cmd_i.scan_run && pend_q && match;
  assign nb       = {2'b0, brk_q} + HDR + {2'b0, want_q};
  assign brk_pay  = {2'b0, brk_q} + HDR;
  assign old_last = ((CW'(old_idx_q) + CW'(1)) == ecount_q);
  assign rd_idx   = (idx_q < MAX_CNT) ? idx_q[IW-1:0] : '0;

  always_comb begin
    sts_o.req_type   = ffh_pkg::req_e'(type_q);
    sts_o.bytes_zero = (bytes_q == '0);
    sts_o.count_zero = (elem_q == '0);
    sts_o.addr_zero  = (addr_q == '0);
    sts_o.prod_ovf   = |(prod_q >> ADDR_BITS);
    sts_o.scan_hit   = hit;
    sts_o.scan_done  = !pend_q && (idx_q >= ecount_q);
    sts_o.size_ok    = (r_size >= want_q);
    sts_o.table_full = (ecount_q >= MAX_CNT);
    sts_o.heap_over  = (nb > SW'(limit_i)) || ((nb >> ADDR_BITS) != '0);
    sts_o.out_free   = !out_valid_q || rsp_ready_i;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    if (hit && !mode_q) begin
      mem_we = 1'b1;
      mem_wa = pidx_q;
      mem_wd = {r_start, r_size, 1'b0};
    end else if (cmd_i.append) begin
      mem_we = 1'b1;
      mem_wa = ecount_q[IW-1:0];
      mem_wd = {brk_q, want_q, 1'b0};
    end else if (cmd_i.release_old && !old_last) begin
      mem_we = 1'b1;
      mem_wa = old_idx_q;
      mem_wd = {old_start_q, old_size_q, 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[rd_idx];
  end

  // request payload, multiply, scan results
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      type_q  <= req_type_i;
      bytes_q <= request_bytes_i;
      elem_q  <= element_count_i;
      addr_q  <= address_i;
      want_q  <= VW'(request_bytes_i);
    end
    if (cmd_i.mul) prod_q <= elem_q * bytes_q;
    if (cmd_i.want_prod) want_q <= prod_q[VW-1:0];
    if (cmd_i.scan_start) begin
      idx_q  <= '0;
      mode_q <= cmd_i.scan_addr;
    end else if (cmd_i.scan_run && (idx_q < ecount_q)) begin
      idx_q  <= idx_q + CW'(1);
      pidx_q <= idx_q[IW-1:0];
    end
    if (hit && mode_q) begin
      old_idx_q   <= pidx_q;
      old_start_q <= r_start;
      old_size_q  <= r_size;
    end
    if (hit && !mode_q) res_q <= r_pay[31:0];
    else if (cmd_i.append) res_q <= brk_pay[31:0];
    else if (cmd_i.res_addr) res_q <= addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      ecount_q <= '0;
      brk_q    <= '0;
    end else begin
      if (cmd_i.scan_start) pend_q <= 1'b0;
      else if (cmd_i.scan_run) pend_q <= (idx_q < ecount_q);
      if (cmd_i.append) begin
        ecount_q <= ecount_q + CW'(1);
        brk_q    <= nb[VW-1:0];
      end else if (cmd_i.release_old && old_last) begin
        ecount_q <= ecount_q - CW'(1);
        brk_q    <= old_start_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o         <= cmd_i.out_status;
      result_address_o <= cmd_i.out_res ? res_q : '0;
      zero_fill_o      <= cmd_i.out_zf;
      copy_source_o    <= cmd_i.out_move ? addr_q : '0;
      copy_bytes_o     <= cmd_i.out_move ? old_size_q[31:0] : '0;
    end
  end

  assign rsp_valid_o = out_valid_q;

  `FFH_ASSERT(a_count_max, (ecount_q <= MAX_CNT), "entry count above table depth")
  `FFH_ASSERT(a_append_room, cmd_i.append |-> (ecount_q < MAX_CNT), "append into full table")
  `FFH_ASSERT(a_release_any, cmd_i.release_old |-> (ecount_q != '0), "release on empty table")
  `FFH_ASSERT(a_load_free, cmd_i.out_load |-> (!out_valid_q || rsp_ready_i), "result overwritten")

endmodule

>>> sv/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator
//
//  channel   dir  handshake         payload
//  req_i     in   valid/ready       req_type, request_bytes, element_count, address
//  rsp_o     out  valid/ready       status, result_address, zero_fill, copy_source, copy_bytes
//  apb       in   psel/penable      heap_limit_bytes at byte address 0
//
// One request at a time; the entry memory is walked one entry per cycle on its single
// read port. A zeroed alloc first multiplies and checks the product for overflow, and the next
// request is taken in the idle state that follows each response.
// No clearing pass after reset. A stalled result is held in the output register while the
// next request is taken; that request then waits to respond until the result leaves.
`timescale 1ns / 1ps
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = ffh_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffh_pkg::HEADER_BYTES_DEF,
  parameter int ADDR_BITS    = ffh_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ffh_req_if.sink                     req_i,
  ffh_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffh_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  ffh_pkg::cmd_t cmd;
  ffh_pkg::sts_t sts;
  logic [31:0]   limit_q;
  logic          sel_limit;

  assign sel_limit = (paddr[2] == ffh_pkg::CFG_HEAP_LIMIT);
  assign pready    = 1'b1;
  assign prdata    = sel_limit ? limit_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ffh_pkg::HEAP_LIMIT_RST;
    end else if (psel && penable && pwrite && sel_limit) begin
      limit_q <= pwdata;
    end
  end

  ffh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffh_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .limit_i          (limit_q),
    .req_type_i       (req_i.req_type),
    .request_bytes_i  (req_i.request_bytes),
    .element_count_i  (req_i.element_count),
    .address_i        (req_i.address),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .status_o         (rsp_o.status),
    .result_address_o (rsp_o.result_address),
    .zero_fill_o      (rsp_o.zero_fill),
    .copy_source_o    (rsp_o.copy_source),
    .copy_bytes_o     (rsp_o.copy_bytes)
  );

endmodule
